// File: rtl/pic_brf_pkg.sv
// Package for the banked register file: sizes, file numbers, bit masks,
// payload structs and the file decode function. No dependencies.
package pic_brf_pkg;

  // Sizes
  localparam int unsigned NUM_FILES    = 48;
  localparam int unsigned EEPROM_DEPTH = 64;
  localparam int unsigned FILE_AW      = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int unsigned EE_AW        = (EEPROM_DEPTH > 1) ? $clog2(EEPROM_DEPTH) : 1;

  // File numbers
  localparam logic [6:0] FILE_INDF   = 7'd0;
  localparam logic [6:0] FILE_OPTION = 7'd1;
  localparam logic [6:0] FILE_STATUS = 7'd3;
  localparam logic [6:0] FILE_FSR    = 7'd4;
  localparam logic [6:0] FILE_PORTA  = 7'd5;
  localparam logic [6:0] FILE_PORTB  = 7'd6;
  localparam logic [6:0] FILE_UNIMPL = 7'd7;
  localparam logic [6:0] FILE_EEDATA = 7'd8;
  localparam logic [6:0] FILE_EEADR  = 7'd9;

  // Bit masks and values
  localparam logic [7:0] STATUS_RESET   = 8'h18;
  localparam logic [7:0] STATUS_RO_MASK = 8'h18;
  localparam logic [7:0] STATUS_WR_MASK = 8'he7;
  localparam int unsigned STATUS_RP0    = 5;
  localparam logic [7:0] BYTE_ONES      = 8'hff;
  localparam logic [7:0] EECON1_HI_MASK = 8'hfc;
  localparam logic [7:0] EECON1_SET_MASK = 8'h03;
  localparam logic [7:0] EE_RD          = 8'h01;
  localparam logic [7:0] EE_WR          = 8'h02;
  localparam logic [7:0] EE_WREN_WR     = 8'h06;
  localparam logic [7:0] EE_EEIF        = 8'h10;
  localparam logic [7:0] UNLOCK_FIRST   = 8'h55;
  localparam logic [7:0] UNLOCK_SECOND  = 8'haa;

  // Operation codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Physical target of an access
  typedef enum logic [3:0] {
    TGT_NONE,
    TGT_GPR,
    TGT_STATUS,
    TGT_FSR,
    TGT_PORTA,
    TGT_PORTB,
    TGT_EEDATA,
    TGT_EEADR,
    TGT_OPTION,
    TGT_TRISA,
    TGT_TRISB,
    TGT_EECON1,
    TGT_EECON2
  } tgt_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] file_address;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [FILE_AW-1:0] addr;
    logic [7:0]         data;
  } gpr_wr_t;

  typedef struct packed {
    logic             we;
    logic [EE_AW-1:0] addr;
    logic [7:0]       data;
  } ee_wr_t;

  // Map bank and file number to a target
  function automatic tgt_e locate(input logic bank, input logic [6:0] file);
    tgt_e t;
    t = TGT_GPR;
    if (({1'b0, file} >= 8'(NUM_FILES)) || (file == FILE_INDF) || (file == FILE_UNIMPL)) begin
      t = TGT_NONE;
    end else if (bank) begin
      case (file)
        FILE_OPTION: t = TGT_OPTION;
        FILE_STATUS: t = TGT_STATUS;
        FILE_FSR:    t = TGT_FSR;
        FILE_PORTA:  t = TGT_TRISA;
        FILE_PORTB:  t = TGT_TRISB;
        FILE_EEDATA: t = TGT_EECON1;
        FILE_EEADR:  t = TGT_EECON2;
        default:     t = TGT_GPR;
      endcase
    end else begin
      case (file)
        FILE_STATUS: t = TGT_STATUS;
        FILE_FSR:    t = TGT_FSR;
        FILE_PORTA:  t = TGT_PORTA;
        FILE_PORTB:  t = TGT_PORTB;
        FILE_EEDATA: t = TGT_EEDATA;
        FILE_EEADR:  t = TGT_EEADR;
        default:     t = TGT_GPR;
      endcase
    end
    return t;
  endfunction

endpackage

// File: rtl/pic_brf_ram.sv
// Byte memory with per-entry valid bits, registered read and write-to-read
// forwarding. Stand-alone, no package use.
module pic_brf_ram #(
  parameter  int unsigned Depth = 64,
  parameter  int unsigned Width = 8,
  localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_q;
  logic [Width-1:0] fwd_data_q;
  logic [Depth-1:0] valid_q;
  logic             hit_d, hit_q;
  logic             ok_d, ok_q;

  // Storage array and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q       <= mem_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // A write to the address being read this edge is forwarded
  assign hit_d = we_i && !clear_i && (waddr_i == raddr_i);
  assign ok_d  = !clear_i && valid_q[raddr_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      hit_q <= hit_d;
      ok_q  <= ok_d;
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  // Entries never written since reset or clear read as zero
  assign rdata_o = hit_q ? fwd_data_q : (ok_q ? rd_q : '0);

endmodule

// File: rtl/pic_brf_core.sv
// Access logic and special registers of the register file: bank decode,
// port/TRIS masking, EECON1/EECON2 handling. Uses pic_brf_pkg.
module pic_brf_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               ex_valid_i,
  input  pic_brf_pkg::req_t                  req_i,
  input  logic [7:0]                         gpr_rdata_i,
  input  logic [7:0]                         ee_rdata_i,
  output pic_brf_pkg::gpr_wr_t               gpr_wr_o,
  output pic_brf_pkg::ee_wr_t                ee_wr_o,
  output logic                               clear_o,
  output logic [6:0]                         ind_file_nxt_o,
  output logic [7:0]                         eeadr_nxt_o,
  output pic_brf_pkg::rsp_t                  rsp_o
);

  logic [7:0] status_q, status_d;
  logic [7:0] fsr_q, fsr_d;
  logic [7:0] porta_q, porta_d;
  logic [7:0] portb_q, portb_d;
  logic [7:0] eedata_q, eedata_d;
  logic [7:0] eeadr_q, eeadr_d;
  logic [7:0] option_q, option_d;
  logic [7:0] trisa_q, trisa_d;
  logic [7:0] trisb_q, trisb_d;
  logic [7:0] eecon1_q, eecon1_d;
  logic [7:0] eecon2_q, eecon2_d;
  logic [7:0] latch_a_q, latch_a_d;
  logic [7:0] latch_b_q, latch_b_d;
  logic       armed_q, armed_d;
  pic_brf_pkg::tgt_e ind_tgt_q, ind_tgt_d;
  logic [6:0] ind_file_q, ind_file_d;

  pic_brf_pkg::tgt_e tgt;
  logic       is_ind;
  logic [6:0] idx;
  logic [7:0] wval;
  logic [7:0] rd_val;
  logic       ee_inrange;
  logic [7:0] ee_val;

  // Decode the target of the current item
  assign is_ind = (req_i.file_address == pic_brf_pkg::FILE_INDF);
  assign tgt    = is_ind ? ind_tgt_q
                         : pic_brf_pkg::locate(status_q[pic_brf_pkg::STATUS_RP0],
                                               req_i.file_address);
  assign idx    = is_ind ? ind_file_q : req_i.file_address;
  assign wval   = req_i.write_data;

  assign ee_inrange = ({1'b0, eeadr_q} < 9'(pic_brf_pkg::EEPROM_DEPTH));
  assign ee_val     = ee_inrange ? ee_rdata_i : 8'h00;

  // Read mux over targets
  always_comb begin
    case (tgt)
      pic_brf_pkg::TGT_GPR:    rd_val = gpr_rdata_i;
      pic_brf_pkg::TGT_STATUS: rd_val = status_q;
      pic_brf_pkg::TGT_FSR:    rd_val = fsr_q;
      pic_brf_pkg::TGT_PORTA:  rd_val = porta_q;
      pic_brf_pkg::TGT_PORTB:  rd_val = portb_q;
      pic_brf_pkg::TGT_EEDATA: rd_val = eedata_q;
      pic_brf_pkg::TGT_EEADR:  rd_val = eeadr_q;
      pic_brf_pkg::TGT_OPTION: rd_val = option_q;
      pic_brf_pkg::TGT_TRISA:  rd_val = trisa_q;
      pic_brf_pkg::TGT_TRISB:  rd_val = trisb_q;
      pic_brf_pkg::TGT_EECON1: rd_val = eecon1_q;
      pic_brf_pkg::TGT_EECON2: rd_val = eecon2_q;
      default:                 rd_val = 8'h00;
    endcase
  end

  // Next state, memory writes and result
  always_comb begin
    status_d   = status_q;
    fsr_d      = fsr_q;
    porta_d    = porta_q;
    portb_d    = portb_q;
    eedata_d   = eedata_q;
    eeadr_d    = eeadr_q;
    option_d   = option_q;
    trisa_d    = trisa_q;
    trisb_d    = trisb_q;
    eecon1_d   = eecon1_q;
    eecon2_d   = eecon2_q;
    latch_a_d  = latch_a_q;
    latch_b_d  = latch_b_q;
    armed_d    = armed_q;
    ind_tgt_d  = ind_tgt_q;
    ind_file_d = ind_file_q;
    gpr_wr_o   = '0;
    ee_wr_o    = '0;
    clear_o    = 1'b0;
    rsp_o      = '0;

    if (ex_valid_i) begin
      case (pic_brf_pkg::op_e'(req_i.operation))
        pic_brf_pkg::OP_CLEAR: begin
          // Everything back to reset, indirect target and unlock arm kept
          status_d  = pic_brf_pkg::STATUS_RESET;
          fsr_d     = 8'h00;
          porta_d   = 8'h00;
          portb_d   = 8'h00;
          eedata_d  = 8'h00;
          eeadr_d   = 8'h00;
          option_d  = pic_brf_pkg::BYTE_ONES;
          trisa_d   = pic_brf_pkg::BYTE_ONES;
          trisb_d   = pic_brf_pkg::BYTE_ONES;
          eecon1_d  = 8'h00;
          eecon2_d  = 8'h00;
          latch_a_d = 8'h00;
          latch_b_d = 8'h00;
          clear_o   = 1'b1;
        end

        pic_brf_pkg::OP_READ: begin
          if (tgt == pic_brf_pkg::TGT_NONE) begin
            rsp_o.status = 1'b1;
          end else begin
            rsp_o.read_data = rd_val;
          end
        end

        pic_brf_pkg::OP_WRITE: begin
          if (tgt == pic_brf_pkg::TGT_NONE) begin
            rsp_o.status = 1'b1;
          end else begin
            case (tgt)
              pic_brf_pkg::TGT_GPR: begin
                gpr_wr_o.we   = 1'b1;
                gpr_wr_o.addr = idx[pic_brf_pkg::FILE_AW-1:0];
                gpr_wr_o.data = wval;
              end
              pic_brf_pkg::TGT_STATUS: begin
                status_d = is_ind ? wval
                                  : ((wval & pic_brf_pkg::STATUS_WR_MASK) |
                                     (status_q & pic_brf_pkg::STATUS_RO_MASK));
              end
              pic_brf_pkg::TGT_FSR: begin
                fsr_d = wval;
                // Only a direct FSR write moves the indirect target
                if (!is_ind) begin
                  ind_tgt_d  = pic_brf_pkg::locate(wval[7], wval[6:0]);
                  ind_file_d = wval[6:0];
                end
              end
              pic_brf_pkg::TGT_PORTA: begin
                if (is_ind) begin
                  porta_d = wval;
                end else begin
                  latch_a_d = wval;
                  porta_d   = (wval & ~trisa_q) | (porta_q & trisa_q);
                end
              end
              pic_brf_pkg::TGT_PORTB: begin
                if (is_ind) begin
                  portb_d = wval;
                end else begin
                  latch_b_d = wval;
                  portb_d   = (wval & ~trisb_q) | (portb_q & trisb_q);
                end
              end
              pic_brf_pkg::TGT_TRISA: begin
                trisa_d = wval;
                if (!is_ind) begin
                  porta_d = (latch_a_q & ~wval) | (porta_q & wval);
                end
              end
              pic_brf_pkg::TGT_TRISB: begin
                trisb_d = wval;
                if (!is_ind) begin
                  portb_d = (latch_b_q & ~wval) | (portb_q & wval);
                end
              end
              pic_brf_pkg::TGT_EEDATA: eedata_d = wval;
              pic_brf_pkg::TGT_EEADR:  eeadr_d  = wval;
              pic_brf_pkg::TGT_OPTION: option_d = wval;
              pic_brf_pkg::TGT_EECON1: begin
                // A direct write can only set RD and WR, never clear them; an indirect write stores the byte as it is
                eecon1_d = is_ind ? wval
                                  : ((wval & pic_brf_pkg::EECON1_HI_MASK) |
                                     ((eecon1_q | wval) & pic_brf_pkg::EECON1_SET_MASK));
              end
              pic_brf_pkg::TGT_EECON2: begin
                if (is_ind) begin
                  eecon2_d = wval;
                end else if (armed_q) begin
                  // Second unlock byte commits the EEPROM write when WREN and WR are set
                  if (wval == pic_brf_pkg::UNLOCK_SECOND) begin
                    armed_d = 1'b0;
                    if ((eecon1_q & pic_brf_pkg::EE_WREN_WR) == pic_brf_pkg::EE_WREN_WR) begin
                      ee_wr_o.we   = ee_inrange;
                      ee_wr_o.addr = eeadr_q[pic_brf_pkg::EE_AW-1:0];
                      ee_wr_o.data = eedata_q;
                      eecon1_d     = (eecon1_q & ~pic_brf_pkg::EE_WR) | pic_brf_pkg::EE_EEIF;
                    end
                  end
                end else if (wval == pic_brf_pkg::UNLOCK_FIRST) begin
                  armed_d = 1'b1;
                end
              end
              default: ;
            endcase

            // EEPROM read request completes within the same access
            if ((eecon1_d & pic_brf_pkg::EE_RD) != 8'h00) begin
              eedata_d = ee_val;
              eecon1_d = eecon1_d & ~pic_brf_pkg::EE_RD;
            end
          end
        end

        default: begin
          rsp_o.status = 1'b1;
        end
      endcase
    end
  end

  assign ind_file_nxt_o = ind_file_d;
  assign eeadr_nxt_o    = eeadr_d;

  // Special registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= pic_brf_pkg::STATUS_RESET;
      fsr_q      <= 8'h00;
      porta_q    <= 8'h00;
      portb_q    <= 8'h00;
      eedata_q   <= 8'h00;
      eeadr_q    <= 8'h00;
      option_q   <= pic_brf_pkg::BYTE_ONES;
      trisa_q    <= pic_brf_pkg::BYTE_ONES;
      trisb_q    <= pic_brf_pkg::BYTE_ONES;
      eecon1_q   <= 8'h00;
      eecon2_q   <= 8'h00;
      latch_a_q  <= 8'h00;
      latch_b_q  <= 8'h00;
      armed_q    <= 1'b0;
      ind_tgt_q  <= pic_brf_pkg::TGT_NONE;
      ind_file_q <= 7'd0;
    end else begin
      status_q   <= status_d;
      fsr_q      <= fsr_d;
      porta_q    <= porta_d;
      portb_q    <= portb_d;
      eedata_q   <= eedata_d;
      eeadr_q    <= eeadr_d;
      option_q   <= option_d;
      trisa_q    <= trisa_d;
      trisb_q    <= trisb_d;
      eecon1_q   <= eecon1_d;
      eecon2_q   <= eecon2_d;
      latch_a_q  <= latch_a_d;
      latch_b_q  <= latch_b_d;
      armed_q    <= armed_d;
      ind_tgt_q  <= ind_tgt_d;
      ind_file_q <= ind_file_d;
    end
  end

endmodule

// File: rtl/pic_banked_register_file.sv
// Top level of the banked register file with data EEPROM.
// Uses pic_brf_pkg, pic_brf_ram and pic_brf_core.
//
//   channel   | signals                | transfer when
//   ----------+------------------------+------------------------------
//   request   | start, busy, req_i     | start high while busy is low
//   response  | done_o, rsp_o          | every cycle done_o is high
//
// One request per cycle. A taken request is held in the request register
// while the core executes it, and its response is then shown, with done_o,
// from the response register. busy stays low: the file and EEPROM memories
// are read at the accept edge with the previous request's updates forwarded.
// Reset is asynchronous; memory contents read as zero through per-entry
// valid bits, so no clearing pass is needed. Responses cannot be stalled.
module pic_banked_register_file (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pic_brf_pkg::req_t req_i,
  output logic              done_o,
  output pic_brf_pkg::rsp_t rsp_o
);

  logic                 accept;
  logic                 ex_valid_q;
  pic_brf_pkg::req_t    ex_q;
  logic                 done_q;
  pic_brf_pkg::rsp_t    rsp_q;
  pic_brf_pkg::rsp_t    rsp_d;

  pic_brf_pkg::gpr_wr_t gpr_wr;
  pic_brf_pkg::ee_wr_t  ee_wr;
  logic                 clear;
  logic [6:0]           ind_file_nxt;
  logic [7:0]           eeadr_nxt;
  logic [pic_brf_pkg::FILE_AW-1:0] gpr_raddr;
  logic [pic_brf_pkg::EE_AW-1:0]   ee_raddr;
  logic [7:0]           gpr_rdata;
  logic [7:0]           ee_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else begin
      ex_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_q <= req_i;
    end
  end

  // Read addresses use the state as it stands after the request in flight
  assign gpr_raddr = (req_i.file_address == pic_brf_pkg::FILE_INDF)
                     ? ind_file_nxt[pic_brf_pkg::FILE_AW-1:0]
                     : req_i.file_address[pic_brf_pkg::FILE_AW-1:0];
  assign ee_raddr  = eeadr_nxt[pic_brf_pkg::EE_AW-1:0];

  // General purpose files
  pic_brf_ram #(
    .Depth (pic_brf_pkg::NUM_FILES),
    .Width (8)
  ) u_gpr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .we_i    (gpr_wr.we),
    .waddr_i (gpr_wr.addr),
    .wdata_i (gpr_wr.data),
    .raddr_i (gpr_raddr),
    .rdata_o (gpr_rdata)
  );

  // Data EEPROM
  pic_brf_ram #(
    .Depth (pic_brf_pkg::EEPROM_DEPTH),
    .Width (8)
  ) u_eeprom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .we_i    (ee_wr.we),
    .waddr_i (ee_wr.addr),
    .wdata_i (ee_wr.data),
    .raddr_i (ee_raddr),
    .rdata_o (ee_rdata)
  );

  // Access logic and special registers
  pic_brf_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ex_valid_i     (ex_valid_q),
    .req_i          (ex_q),
    .gpr_rdata_i    (gpr_rdata),
    .ee_rdata_i     (ee_rdata),
    .gpr_wr_o       (gpr_wr),
    .ee_wr_o        (ee_wr),
    .clear_o        (clear),
    .ind_file_nxt_o (ind_file_nxt),
    .eeadr_nxt_o    (eeadr_nxt),
    .rsp_o          (rsp_d)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ex_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: tb/pic_brf_response_checker.sv
`timescale 1ns / 1ps
// Response checker for pic_banked_register_file: keeps its own copy of the file,
// EEPROM and unlock state, predicts every response and compares in order.
// Depends on pic_brf_pkg.
module pic_brf_response_checker
  import pic_brf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic busy_i,
  input  req_t req_i,
  input  logic done_i,
  input  rsp_t rsp_i,
  output int   mismatch_cnt_o,
  output int   pending_o,
  output int   checked_o
);

  // Predicted register file and EEPROM
  logic [7:0] bank0_files [NUM_FILES];
  logic [7:0] eeprom_q    [EEPROM_DEPTH];
  logic [7:0] option_q, tris_a_q, tris_b_q, eecon1_q, eecon2_q;
  logic [7:0] latch_a_q, latch_b_q;
  logic       unlock_armed_q;
  tgt_e       indf_tgt_q;
  logic [6:0] indf_file_q;

  rsp_t predicted_rsp_q [$];
  rsp_t want;

  // Reset values; the indirect target and the unlock arming survive a clear
  function automatic void clear_files();
    for (int i = 0; i < NUM_FILES; i++) bank0_files[i] = '0;
    for (int i = 0; i < EEPROM_DEPTH; i++) eeprom_q[i] = '0;
    bank0_files[FILE_STATUS] = STATUS_RESET;
    option_q  = BYTE_ONES;
    tris_a_q  = BYTE_ONES;
    tris_b_q  = BYTE_ONES;
    eecon1_q  = '0;
    eecon2_q  = '0;
    latch_a_q = '0;
    latch_b_q = '0;
  endfunction

  // Where a file of a bank lives: a bank 0 file or one of the bank 1 registers
  function automatic tgt_e decode_file(logic bank, logic [6:0] f);
    if (int'(f) >= NUM_FILES || f == FILE_INDF || f == FILE_UNIMPL) return TGT_NONE;
    if (bank) begin
      case (f)
        FILE_OPTION: return TGT_OPTION;
        FILE_PORTA:  return TGT_TRISA;
        FILE_PORTB:  return TGT_TRISB;
        FILE_EEDATA: return TGT_EECON1;
        FILE_EEADR:  return TGT_EECON2;
        default: ;
      endcase
    end
    return TGT_GPR;
  endfunction

  // Raw store, no side effects
  function automatic void store_target(tgt_e tgt, logic [6:0] f, logic [7:0] v);
    case (tgt)
      TGT_OPTION: option_q = v;
      TGT_TRISA:  tris_a_q = v;
      TGT_TRISB:  tris_b_q = v;
      TGT_EECON1: eecon1_q = v;
      TGT_EECON2: eecon2_q = v;
      default:    bank0_files[f] = v;
    endcase
  endfunction

  // Direct write with the special register rules
  function automatic void direct_write(tgt_e tgt, logic [6:0] f, logic [7:0] v);
    logic [7:0] a;
    case (tgt)
      TGT_TRISA: begin
        tris_a_q = v;
        bank0_files[FILE_PORTA] = (latch_a_q & ~v) | (bank0_files[FILE_PORTA] & v);
      end
      TGT_TRISB: begin
        tris_b_q = v;
        bank0_files[FILE_PORTB] = (latch_b_q & ~v) | (bank0_files[FILE_PORTB] & v);
      end
      // A direct write can only set RD and WR, never clear them
      TGT_EECON1: begin
        eecon1_q = (v & EECON1_HI_MASK) | ((eecon1_q | v) & EECON1_SET_MASK);
      end
      // unlock: first key arms, second key fires the program if WREN and WR
      TGT_EECON2: begin
        if (unlock_armed_q) begin
          if (v == UNLOCK_SECOND) begin
            if ((eecon1_q & EE_WREN_WR) == EE_WREN_WR) begin
              a = bank0_files[FILE_EEADR];
              if (a < EEPROM_DEPTH) eeprom_q[a[EE_AW-1:0]] = bank0_files[FILE_EEDATA];
              eecon1_q = (eecon1_q & ~EE_WR) | EE_EEIF;
            end
            unlock_armed_q = 1'b0;
          end
        end else if (v == UNLOCK_FIRST) begin
          unlock_armed_q = 1'b1;
        end
      end
      TGT_GPR: begin
        case (f)
          FILE_STATUS: begin
            bank0_files[FILE_STATUS] = (v & STATUS_WR_MASK) |
                                       (bank0_files[FILE_STATUS] & STATUS_RO_MASK);
          end
          FILE_FSR: begin
            indf_tgt_q  = decode_file(v[7], v[6:0]);
            indf_file_q = v[6:0];
            bank0_files[FILE_FSR] = v;
          end
          FILE_PORTA: begin
            latch_a_q = v;
            bank0_files[FILE_PORTA] = (v & ~tris_a_q) | (bank0_files[FILE_PORTA] & tris_a_q);
          end
          FILE_PORTB: begin
            latch_b_q = v;
            bank0_files[FILE_PORTB] = (v & ~tris_b_q) | (bank0_files[FILE_PORTB] & tris_b_q);
          end
          default: bank0_files[f] = v;
        endcase
      end
      default: store_target(tgt, f, v);
    endcase
  endfunction

  // One access: updates the predicted state and returns the expected response
  function automatic rsp_t run_access(req_t r);
    rsp_t       rsp;
    tgt_e       tgt;
    logic [6:0] f;
    logic [7:0] a;
    rsp = '0;
    case (r.operation)
      OP_CLEAR: begin
        clear_files();
        return rsp;
      end
      OP_READ, OP_WRITE: ;
      default: begin
        rsp.status = 1'b1;
        return rsp;
      end
    endcase
    if (r.file_address == FILE_INDF) begin
      tgt = indf_tgt_q;
      f   = indf_file_q;
    end else begin
      tgt = decode_file(bank0_files[FILE_STATUS][STATUS_RP0], r.file_address);
      f   = r.file_address;
    end
    if (tgt == TGT_NONE) begin
      rsp.status = 1'b1;
      return rsp;
    end
    if (r.operation == OP_READ) begin
      case (tgt)
        TGT_OPTION: rsp.read_data = option_q;
        TGT_TRISA:  rsp.read_data = tris_a_q;
        TGT_TRISB:  rsp.read_data = tris_b_q;
        TGT_EECON1: rsp.read_data = eecon1_q;
        TGT_EECON2: rsp.read_data = eecon2_q;
        default:    rsp.read_data = bank0_files[f];
      endcase
      return rsp;
    end
    if (r.file_address == FILE_INDF) store_target(tgt, f, r.write_data);
    else direct_write(tgt, f, r.write_data);
    // a pending RD loads EEDATA after every write
    if ((eecon1_q & EE_RD) != '0) begin
      a = bank0_files[FILE_EEADR];
      if (a < EEPROM_DEPTH) bank0_files[FILE_EEDATA] = eeprom_q[a[EE_AW-1:0]];
      else bank0_files[FILE_EEDATA] = '0;
      eecon1_q = eecon1_q & ~EE_RD;
    end
    return rsp;
  endfunction

  // Compare responses first (they belong to older requests), then predict
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_files();
      unlock_armed_q = 1'b0;
      indf_tgt_q     = TGT_NONE;
      indf_file_q    = '0;
      predicted_rsp_q.delete();
      mismatch_cnt_o = 0;
      pending_o      = 0;
      checked_o      = 0;
    end else begin
      if (done_i) begin
        checked_o++;
        if (predicted_rsp_q.size() == 0) begin
          if (mismatch_cnt_o < 10) begin
            $display("response %0d with no request outstanding: read_data %02h status %0b",
                     checked_o, rsp_i.read_data, rsp_i.status);
          end
          mismatch_cnt_o++;
        end else begin
          want = predicted_rsp_q.pop_front();
          if (rsp_i.read_data !== want.read_data || rsp_i.status !== want.status) begin
            if (mismatch_cnt_o < 10) begin
              $display("response %0d: expected read_data %02h status %0b, got %02h status %0b",
                       checked_o, want.read_data, want.status, rsp_i.read_data, rsp_i.status);
            end
            mismatch_cnt_o++;
          end
        end
      end
      if (start_i && !busy_i) predicted_rsp_q.push_back(run_access(req_i));
      pending_o = predicted_rsp_q.size();
    end
  end

endmodule

// File: tb/pic_banked_register_file_tb.sv
`timescale 1ns / 1ps
// Top of the pic_banked_register_file testbench: clock, reset, request stimulus
// and verdict. Depends on pic_brf_pkg, the block and pic_brf_response_checker.
module pic_banked_register_file_tb;
  import pic_brf_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [6:0] FILE_TRISA  = FILE_PORTA;
  localparam logic [6:0] FILE_TRISB  = FILE_PORTB;
  localparam logic [6:0] FILE_EECON1 = FILE_EEDATA;
  localparam logic [6:0] FILE_EECON2 = FILE_EEADR;
  localparam int N_ITEMS     = 1300;
  localparam int MAX_GAP     = 13;
  localparam int STALL_LIMIT = 1000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  req_t req;
  rsp_t rsp;

  int mismatch_cnt, pending, checked;
  int n_sent = 0, n_read = 0, n_write = 0, n_clear = 0, n_unused = 0, n_unlock = 0;
  int stall_cycles = 0;
  bit no_gaps = 1'b0;
  bit paused_mid = 1'b0;

  pic_banked_register_file dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp)
  );

  pic_brf_response_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .done_i         (done_o),
    .rsp_i          (rsp),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Watchdog: cycles without any request or response transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("pic_banked_register_file regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // One request transfer, after a random idle gap unless gaps are turned off
  task automatic send(input logic [1:0] op, input logic [6:0] file, input logic [7:0] data);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= '{operation: op, file_address: file, write_data: data};
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    n_sent++;
    case (op)
      OP_READ:  n_read++;
      OP_WRITE: n_write++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
  endtask

  // Hold requests off until every predicted response has come back
  task automatic await_idle();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // STATUS write with random flag bits and the given bank select
  task automatic select_bank(input logic bank);
    logic [7:0] d;
    d = 8'($urandom);
    d[STATUS_RP0] = bank;
    send(OP_WRITE, FILE_STATUS, d);
  endtask

  // EEPROM address, now and then beyond the array
  function automatic logic [7:0] pick_ee_addr();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(EEPROM_DEPTH, 255));
    return 8'($urandom_range(0, EEPROM_DEPTH - 1));
  endfunction

  initial begin : stimulus
    logic [7:0] d;
    logic [7:0] ctl;
    logic [6:0] file;
    logic [1:0] op;
    int pick;
    int n;
    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, unmapped and out-of-range files, read-only
    // STATUS bits, bank 1 registers, EEPROM program and read, indirect access
    send(OP_READ, FILE_STATUS, 8'h00);
    send(OP_READ, FILE_INDF, 8'hff);
    send(OP_READ, FILE_UNIMPL, 8'h00);
    send(OP_WRITE, 7'(NUM_FILES), 8'hff);
    send(OP_READ, 7'h7f, 8'hff);
    send(OP_WRITE, 7'(NUM_FILES - 1), 8'hff);
    send(OP_READ, 7'(NUM_FILES - 1), 8'h00);
    send(OP_WRITE, FILE_STATUS, 8'h00);
    send(OP_WRITE, FILE_EEADR, 8'(EEPROM_DEPTH - 1));
    send(OP_WRITE, FILE_EEDATA, 8'ha5);
    send(OP_WRITE, FILE_PORTA, 8'h5a);
    send(OP_WRITE, FILE_STATUS, 8'hff);
    send(OP_WRITE, FILE_TRISA, 8'h0f);
    send(OP_WRITE, FILE_EECON1, EE_WREN_WR);
    send(OP_WRITE, FILE_EECON2, UNLOCK_FIRST);
    send(OP_WRITE, FILE_EECON2, UNLOCK_SECOND);
    send(OP_READ, FILE_EECON1, 8'h00);
    send(OP_WRITE, FILE_EECON1, EE_RD);
    send(OP_WRITE, FILE_FSR, 8'h81);
    send(OP_WRITE, FILE_INDF, 8'h5a);
    send(OP_READ, FILE_OPTION, 8'h00);
    send(OP_WRITE, FILE_FSR, 8'(NUM_FILES));
    send(OP_READ, FILE_INDF, 8'h00);
    send(OP_UNUSED, 7'h7f, 8'hff);
    send(OP_CLEAR, 7'h00, 8'h00);
    send(OP_READ, FILE_STATUS, 8'h00);
    send(OP_READ, FILE_EEDATA, 8'h00);
    await_idle();

    // Random: mostly well-formed register sequences, the rest loose accesses
    while (n_sent < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) no_gaps = !no_gaps;
      if (n_sent >= N_ITEMS / 2 && !paused_mid) begin
        await_idle();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // EEPROM program, with the odd broken key or missing enable
        select_bank(1'b0);
        send(OP_WRITE, FILE_EEADR, pick_ee_addr());
        send(OP_WRITE, FILE_EEDATA, 8'($urandom));
        select_bank(1'b1);
        ctl = 8'($urandom);
        if ($urandom_range(0, 4) != 0) ctl = (ctl | EE_WREN_WR) & ~EE_RD;
        send(OP_WRITE, FILE_EECON1, ctl);
        send(OP_WRITE, FILE_EECON2, ($urandom_range(0, 5) != 0) ? UNLOCK_FIRST : 8'($urandom));
        send(OP_WRITE, FILE_EECON2, ($urandom_range(0, 5) != 0) ? UNLOCK_SECOND : 8'($urandom));
        n_unlock++;
        if ($urandom_range(0, 1) == 0) send(OP_READ, FILE_EECON1, 8'($urandom));
      end else if (pick < 40) begin
        // EEPROM read back through EEDATA
        select_bank(1'b0);
        send(OP_WRITE, FILE_EEADR, pick_ee_addr());
        select_bank(1'b1);
        send(OP_WRITE, FILE_EECON1, 8'($urandom) | EE_RD);
        select_bank(1'b0);
        send(OP_READ, FILE_EEDATA, 8'($urandom));
      end else if (pick < 55) begin
        // point FSR somewhere, then go through the indirect file
        select_bank(1'($urandom));
        d = {1'($urandom), ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15))};
        send(OP_WRITE, FILE_FSR, d);
        n = $urandom_range(1, 4);
        repeat (n) send(($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE, FILE_INDF, 8'($urandom));
      end else if (pick < 65) begin
        // TRIS masks, port latches, port read back
        select_bank(1'b1);
        send(OP_WRITE, FILE_TRISA, 8'($urandom));
        send(OP_WRITE, FILE_TRISB, 8'($urandom));
        select_bank(1'b0);
        send(OP_WRITE, FILE_PORTA, 8'($urandom));
        send(OP_WRITE, FILE_PORTB, 8'($urandom));
        send(OP_READ, FILE_PORTA, 8'($urandom));
        send(OP_READ, FILE_PORTB, 8'($urandom));
      end else begin
        // loose access anywhere, including clears and the unused code
        pick = $urandom_range(0, 99);
        if (pick < 46) op = OP_READ;
        else if (pick < 95) op = OP_WRITE;
        else if (pick < 98) op = OP_CLEAR;
        else op = OP_UNUSED;
        file = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 15));
        send(op, file, 8'($urandom));
      end
    end

    await_idle();
    repeat (8) @(posedge clk_i);
    $display("covered %0d requests: %0d reads, %0d writes, %0d clears, %0d unused codes",
             n_sent, n_read, n_write, n_clear, n_unused);
    $display("%0d responses checked, %0d EEPROM unlock attempts, %0d mismatches",
             checked, n_unlock, mismatch_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("pic_banked_register_file regression: pass");
    end else begin
      $display("pic_banked_register_file regression: fail");
    end
    $finish;
  end

endmodule
